/* sv/unf_pkg.sv */
package unf_pkg;

    localparam int CP_W = 21;

    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] MARK_LEAD = 8'hCC;

    typedef logic [CP_W-1:0] cp_t;
    typedef logic [3:0][7:0] seq_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } src_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_run_end;
        logic       out_stream_end;
    } dst_t;

    // base letter of latin-1 0xc0..0xff, zero where the letter is not split
    function automatic logic [7:0] base_of(input logic [5:0] k);
        logic [7:0] b;
        b = 8'h00;
        case (k[4:0]) inside
            [5'h00:5'h05]: b = 8'h41;
            5'h07:         b = 8'h43;
            [5'h08:5'h0B]: b = 8'h45;
            [5'h0C:5'h0F]: b = 8'h49;
            5'h11:         b = 8'h4E;
            [5'h12:5'h16]: b = 8'h4F;
            5'h18:         b = 8'h4F;
            [5'h19:5'h1C]: b = 8'h55;
            default:       b = 8'h00;
        endcase
        if (b != 8'h00)
        begin
            b = b | {2'b00, k[5], 5'b00000};
        end
        return b;
    endfunction

    // low byte of the combining mark u+03xx
    function automatic logic [7:0] mark_of(input logic [5:0] k);
        logic [7:0] m;
        m = 8'h00;
        case (k[4:0]) inside
            5'h00, 5'h08, 5'h0C, 5'h12, 5'h19: m = 8'h00;
            5'h01, 5'h09, 5'h0D, 5'h13, 5'h1A: m = 8'h01;
            5'h02, 5'h0A, 5'h0E, 5'h14, 5'h1B: m = 8'h02;
            5'h03, 5'h11, 5'h15:               m = 8'h03;
            5'h04, 5'h0B, 5'h0F, 5'h16, 5'h1C: m = 8'h08;
            5'h05:                             m = 8'h0A;
            5'h07:                             m = 8'h27;
            5'h18:                             m = 8'h37;
            default:                           m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

/* sv/utf8_or_latin1_decomposing_normalizer.sv */
// utf-8 / latin-1 to decomposed utf-8 normalizer
// src channel: one request per input byte (src_data.in_byte, src_data.in_last),
// taken at a clock edge with src_valid high and src_stall low
// dst channel: one output byte per request on dst, with out_run_end on the
// last byte caused by an input byte and out_stream_end on the last byte of
// a string (in_last set)
// an input byte may cause no output (a lead byte waiting for continuation
// bytes) or up to ten bytes (a flushed sequence decoded as latin-1, with split letters)
// a shared decode/encode unit handles one code point at a time under a
// small sequencer: the idle step takes the byte, then per code point a scan
// step decodes it and the emit step gives its 1 to 4 output bytes, one per
// cycle while dst does not stall, then a closing scan step returns to idle
// the emit step after the first scan step loads the first output byte into dst
// src_stall is high while an item is in work
// a stall on dst holds the output register and keeps the sequencer in its emit step
// reset clears the pending lead bytes and empties the output register
module utf8_or_latin1_decomposing_normalizer
    import unf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic src_valid,
    output logic src_stall,
    input  src_t src_data,
    output logic dst_valid,
    input  logic dst_stall,
    output dst_t dst_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       pend;
        logic [2:0] adv;
        cp_t        cp;
    } dec_t;

    function automatic dec_t decide(
        input seq_t       b,
        input logic [2:0] n,
        input logic [2:0] p,
        input logic       lst
    );
        dec_t       d;
        logic [7:0] c;
        logic [2:0] need;
        logic [2:0] avail;
        logic [2:0] chk;
        logic       ok;
        logic [1:0] i1;
        logic [1:0] i2;
        logic [1:0] i3;
        d     = '0;
        c     = b[p[1:0]];
        i1    = p[1:0] + 2'd1;
        i2    = p[1:0] + 2'd2;
        i3    = p[1:0] + 2'd3;
        if (c[7:5] == 3'b110)
        begin
            need = 3'd1;
        end
        else if (c[7:4] == 4'b1110)
        begin
            need = 3'd2;
        end
        else if (c[7:3] == 5'b11110)
        begin
            need = 3'd3;
        end
        else
        begin
            need = 3'd0;
        end
        avail = n - p - 3'd1;
        chk   = (need < avail) ? need : avail;
        ok    = 1'b1;
        if (chk >= 3'd1 && b[i1][7:6] != 2'b10)
        begin
            ok = 1'b0;
        end
        if (chk >= 3'd2 && b[i2][7:6] != 2'b10)
        begin
            ok = 1'b0;
        end
        if (chk >= 3'd3 && b[i3][7:6] != 2'b10)
        begin
            ok = 1'b0;
        end
        if (need == 3'd0 || !ok)
        begin
            d.cp  = {13'd0, c};
            d.adv = 3'd1;
        end
        else if (avail >= need)
        begin
            d.adv = need + 3'd1;
            case (need)
                3'd1:    d.cp = {10'd0, c[4:0], b[i1][5:0]};
                3'd2:    d.cp = {5'd0, c[3:0], b[i1][5:0], b[i2][5:0]};
                default: d.cp = {c[2:0], b[i1][5:0], b[i2][5:0], b[i3][5:0]};
            endcase
        end
        else if (lst)
        begin
            d.cp  = {13'd0, c};
            d.adv = 3'd1;
        end
        else
        begin
            d.pend = 1'b1;
        end
        return d;
    endfunction

    state_t     state_reg,    state_next;
    seq_t       buf_reg,      buf_next;
    logic [1:0] pend_cnt_reg, pend_cnt_next;
    logic [2:0] n_reg,        n_next;
    logic [2:0] pos_reg,      pos_next;
    logic       last_reg,     last_next;
    seq_t       seq_reg,      seq_next;
    logic [2:0] len_reg,      len_next;
    logic [1:0] idx_reg,      idx_next;
    logic       more_reg,     more_next;
    logic       out_vld_reg,  out_vld_next;
    dst_t       out_reg,      out_next;

    dec_t       dec_cur;
    dec_t       dec_nxt;
    logic [2:0] pos_adv;
    logic       more;
    seq_t       enc_seq;
    logic [2:0] enc_len;
    logic       out_free;
    logic       idx_last;

    assign dec_cur  = decide(buf_reg, n_reg, pos_reg, last_reg);
    assign pos_adv  = pos_reg + dec_cur.adv;
    assign dec_nxt  = decide(buf_reg, n_reg, pos_adv, last_reg);
    assign more     = (pos_adv < n_reg) && !dec_nxt.pend;
    assign out_free = !out_vld_reg || !dst_stall;
    assign idx_last = (idx_reg == 2'(len_reg - 3'd1));

    unf_enc u_enc (
        .cp  (dec_cur.cp),
        .seq (enc_seq),
        .len (enc_len)
    );

    assign src_stall = (state_reg != ST_IDLE);
    assign dst_valid = out_vld_reg;
    assign dst_data  = out_reg;

    always_comb
    begin
        state_next    = state_reg;
        buf_next      = buf_reg;
        pend_cnt_next = pend_cnt_reg;
        n_next        = n_reg;
        pos_next      = pos_reg;
        last_next     = last_reg;
        seq_next      = seq_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        more_next     = more_reg;
        out_vld_next  = out_vld_reg;
        out_next      = out_reg;
        if (out_vld_reg && !dst_stall)
        begin
            out_vld_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (src_valid)
                begin
                    buf_next[pend_cnt_reg] = src_data.in_byte;
                    n_next                 = {1'b0, pend_cnt_reg} + 3'd1;
                    pos_next               = 3'd0;
                    last_next              = src_data.in_last;
                    state_next             = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pos_reg >= n_reg)
                begin
                    pend_cnt_next = 2'd0;
                    state_next    = ST_IDLE;
                end
                else if (dec_cur.pend)
                begin
                    // keep the unfinished sequence, oldest byte first
                    for (int i = 0; i < 3; i++)
                    begin
                        buf_next[i] = buf_reg[2'(pos_reg + 3'(i))];
                    end
                    pend_cnt_next = 2'(n_reg - pos_reg);
                    state_next    = ST_IDLE;
                end
                else
                begin
                    seq_next   = enc_seq;
                    len_next   = enc_len;
                    idx_next   = 2'd0;
                    pos_next   = pos_adv;
                    more_next  = more;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_vld_next            = 1'b1;
                    out_next.out_byte       = seq_reg[idx_reg];
                    out_next.out_run_end    = idx_last && !more_reg;
                    out_next.out_stream_end = idx_last && !more_reg && last_reg;
                    idx_next                = idx_reg + 2'd1;
                    if (idx_last)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            buf_reg      <= '0;
            pend_cnt_reg <= 2'd0;
            n_reg        <= 3'd0;
            pos_reg      <= 3'd0;
            last_reg     <= 1'b0;
            seq_reg      <= '0;
            len_reg      <= 3'd0;
            idx_reg      <= 2'd0;
            more_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
            out_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            buf_reg      <= buf_next;
            pend_cnt_reg <= pend_cnt_next;
            n_reg        <= n_next;
            pos_reg      <= pos_next;
            last_reg     <= last_next;
            seq_reg      <= seq_next;
            len_reg      <= len_next;
            idx_reg      <= idx_next;
            more_reg     <= more_next;
            out_vld_reg  <= out_vld_next;
            out_reg      <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_stream_end_closes_run: assert property (
        @(posedge clk) disable iff (!rst_n)
        dst_valid && dst_data.out_stream_end |-> dst_data.out_run_end
    ) else $error("stream end without run end");

    a_last_never_pends: assert property (
        @(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && last_reg && pos_reg < n_reg |-> !dec_cur.pend
    ) else $error("bytes left pending at end of string");

    a_output_from_emit: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(dst_valid) |-> $past(state_reg == ST_EMIT)
    ) else $error("output loaded outside emit");
`endif

endmodule

/* sv/unf_enc.sv */
module unf_enc
    import unf_pkg::*;
(
    input  cp_t        cp,
    output seq_t       seq,
    output logic [2:0] len
);

    logic [5:0] k;
    logic [7:0] base;
    logic [7:0] mark;
    logic       split;

    assign k     = cp[5:0];
    assign base  = base_of(k);
    assign mark  = mark_of(k);
    assign split = (cp[CP_W-1:6] == 15'd3) && (base != 8'h00);

    always_comb
    begin
        seq = '0;
        len = 3'd1;
        if (split)
        begin
            seq[0] = base;
            seq[1] = MARK_LEAD;
            seq[2] = CONT_TAG | {2'b00, mark[5:0]};
            len    = 3'd3;
        end
        else if (cp[CP_W-1:7] == '0)
        begin
            seq[0] = cp[7:0];
            len    = 3'd1;
        end
        else if (cp[CP_W-1:11] == '0)
        begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
            len    = 3'd2;
        end
        else if (cp[CP_W-1:16] == '0)
        begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
            len    = 3'd3;
        end
        else
        begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
            len    = 3'd4;
        end
    end

endmodule

/* tb/sv/utf8_or_latin1_decomposing_normalizer_tb.sv */
module utf8_or_latin1_decomposing_normalizer_tb;
    import unf_pkg::*;

    localparam int REQ_TARGET  = 310;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;

    // decomposition of latin-1 0xc0..0xff: base letter (zero where not split)
    localparam logic [7:0] SPLIT_BASE [64] = '{
        "A", "A", "A", "A", "A", "A", 8'h00, "C", "E", "E", "E", "E", "I", "I", "I", "I",
        8'h00, "N", "O", "O", "O", "O", "O", 8'h00, "O", "U", "U", "U", "U", 8'h00, 8'h00, 8'h00,
        "a", "a", "a", "a", "a", "a", 8'h00, "c", "e", "e", "e", "e", "i", "i", "i", "i",
        8'h00, "n", "o", "o", "o", "o", "o", 8'h00, "o", "u", "u", "u", "u", 8'h00, 8'h00, 8'h00
    };
    // low byte of the combining mark u+03xx
    localparam logic [7:0] SPLIT_MARK [64] = '{
        8'h00, 8'h01, 8'h02, 8'h03, 8'h08, 8'h0a, 8'h00, 8'h27,
        8'h00, 8'h01, 8'h02, 8'h08, 8'h00, 8'h01, 8'h02, 8'h08,
        8'h00, 8'h03, 8'h00, 8'h01, 8'h02, 8'h03, 8'h08, 8'h00,
        8'h37, 8'h00, 8'h01, 8'h02, 8'h08, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h01, 8'h02, 8'h03, 8'h08, 8'h0a, 8'h00, 8'h27,
        8'h00, 8'h01, 8'h02, 8'h08, 8'h00, 8'h01, 8'h02, 8'h08,
        8'h00, 8'h03, 8'h00, 8'h01, 8'h02, 8'h03, 8'h08, 8'h00,
        8'h37, 8'h00, 8'h01, 8'h02, 8'h08, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [7:0]      b;
        logic            l;
        logic [1:0]      n_typed;
        logic [2:0][7:0] typed;
    } row_t;

    logic clk;
    logic rst_n;
    logic src_valid;
    logic src_stall;
    src_t src_data;
    logic dst_valid;
    logic dst_stall;
    dst_t dst_data;

    utf8_or_latin1_decomposing_normalizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    // predictor state
    logic [7:0] pend_b [3];
    int         pend_n = 0;
    logic [7:0] step_bytes [$];

    dst_t norm_exp_q [$];
    row_t dir_rows [$];

    int req_cnt   = 0;
    int str_cnt   = 0;
    int out_cnt   = 0;
    int bad_cnt   = 0;
    int split_cnt = 0;
    int quiet_cnt = 0;
    int burst_left = 0;
    bit long_hold = 0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int lead_len(input logic [7:0] c);
        if (c[7:5] == 3'b110)
        begin
            return 1;
        end
        if (c[7:4] == 4'b1110)
        begin
            return 2;
        end
        if (c[7:3] == 5'b11110)
        begin
            return 3;
        end
        return 0;
    endfunction

    function automatic void put_byte(input logic [7:0] v);
        step_bytes.insert(step_bytes.size(), v);
    endfunction

    function automatic void emit_plain(input logic [20:0] cp);
        if (cp <= 21'h7f)
        begin
            put_byte(cp[7:0]);
        end
        else if (cp <= 21'h7ff)
        begin
            put_byte({3'b110, cp[10:6]});
            put_byte({2'b10, cp[5:0]});
        end
        else if (cp <= 21'hffff)
        begin
            put_byte({4'b1110, cp[15:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end
        else
        begin
            put_byte({5'b11110, cp[20:18]});
            put_byte({2'b10, cp[17:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void emit_cp(input logic [20:0] cp);
        if (cp >= 21'hc0 && cp <= 21'hff && SPLIT_BASE[cp[5:0]] != 8'h00)
        begin
            split_cnt++;
            put_byte(SPLIT_BASE[cp[5:0]]);
            emit_plain(21'h300 | {13'd0, SPLIT_MARK[cp[5:0]]});
        end
        else
        begin
            emit_plain(cp);
        end
    endfunction

    // one input byte through the pending buffer, output bytes into step_bytes
    function automatic void normalize_step(input logic [7:0] b, input logic l);
        logic [7:0]  win [4];
        logic [20:0] cp;
        int          n;
        int          pos;
        int          need;
        int          avail;
        int          chk;
        int          k;
        int          i;
        bit          ok;
        step_bytes.delete();
        for (i = 0; i < pend_n; i++)
        begin
            win[i] = pend_b[i];
        end
        win[pend_n] = b;
        n = pend_n + 1;
        pend_n = 0;
        pos = 0;
        while (pos < n)
        begin
            need  = lead_len(win[pos]);
            avail = n - pos - 1;
            chk   = (need < avail) ? need : avail;
            if (need == 0)
            begin
                emit_cp({13'd0, win[pos]});
                pos++;
            end
            else
            begin
                ok = 1'b1;
                for (i = 1; i <= chk; i++)
                begin
                    if (win[pos + i][7:6] != 2'b10)
                    begin
                        ok = 1'b0;
                    end
                end
                if (!ok)
                begin
                    emit_cp({13'd0, win[pos]});
                    pos++;
                end
                else if (avail >= need)
                begin
                    case (need)
                        1: cp = {10'd0, win[pos][4:0], win[pos + 1][5:0]};
                        2: cp = {5'd0, win[pos][3:0], win[pos + 1][5:0], win[pos + 2][5:0]};
                        default:
                            cp = {win[pos][2:0], win[pos + 1][5:0], win[pos + 2][5:0],
                                  win[pos + 3][5:0]};
                    endcase
                    emit_cp(cp);
                    pos += need + 1;
                end
                else if (l)
                begin
                    emit_cp({13'd0, win[pos]});
                    pos++;
                end
                else
                begin
                    k = n - pos;
                    for (i = 0; i < k; i++)
                    begin
                        pend_b[i] = win[pos + i];
                    end
                    pend_n = k;
                    pos = n;
                end
            end
        end
    endfunction

    function automatic int gap_len();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic add_row(input logic [7:0] b, input logic l, input logic [1:0] n,
                           input logic [7:0] t0, input logic [7:0] t1, input logic [7:0] t2);
        row_t r;
        r.b = b;
        r.l = l;
        r.n_typed = n;
        r.typed = {t2, t1, t0};
        dir_rows.insert(dir_rows.size(), r);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_req(input row_t r);
        src_t s;
        dst_t e;
        int   g;
        int   i;
        s.in_byte = r.b;
        s.in_last = r.l;
        src_data  <= s;
        src_valid <= 1'b1;
        @(posedge clk);
        while (src_stall)
        begin
            @(posedge clk);
        end
        req_cnt++;
        normalize_step(r.b, r.l);
        if (r.n_typed != 2'd0)
        begin
            step_bytes.delete();
            for (i = 0; i < r.n_typed; i++)
            begin
                put_byte(r.typed[i]);
            end
        end
        for (i = 0; i < step_bytes.size(); i++)
        begin
            e.out_byte       = step_bytes[i];
            e.out_run_end    = (i == step_bytes.size() - 1);
            e.out_stream_end = (i == step_bytes.size() - 1) && r.l;
            norm_exp_q.insert(norm_exp_q.size(), e);
        end
        g = gap_len();
        @(negedge clk);
        if (g > 0)
        begin
            src_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic drain_pause();
        src_valid <= 1'b0;
        while (norm_exp_q.size() != 0)
        begin
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_string();
        logic [7:0] str_q [$];
        logic [7:0] lead;
        row_t       r;
        int         pieces;
        int         kind;
        int         m;
        int         p;
        int         i;
        pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
        for (p = 0; p < pieces; p++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 25)
            begin
                str_q.insert(str_q.size(), 8'($urandom_range(0, 127)));
            end
            else if (kind < 45)
            begin
                // half of them are encoded latin-1 letters, most of which split
                str_q.insert(str_q.size(),
                             $urandom_range(0, 1) ? 8'hc3 : 8'($urandom_range(8'hc0, 8'hdf)));
                str_q.insert(str_q.size(), 8'($urandom_range(8'h80, 8'hbf)));
            end
            else if (kind < 58)
            begin
                str_q.insert(str_q.size(), 8'($urandom_range(8'he0, 8'hef)));
                repeat (2) str_q.insert(str_q.size(), 8'($urandom_range(8'h80, 8'hbf)));
            end
            else if (kind < 68)
            begin
                str_q.insert(str_q.size(), 8'($urandom_range(8'hf0, 8'hf7)));
                repeat (3) str_q.insert(str_q.size(), 8'($urandom_range(8'h80, 8'hbf)));
            end
            else if (kind < 80)
            begin
                str_q.insert(str_q.size(), 8'($urandom_range(8'h80, 8'hff)));
            end
            else if (kind < 92)
            begin
                // broken sequence
                lead = 8'($urandom_range(8'hc0, 8'hf7));
                str_q.insert(str_q.size(), lead);
                m = $urandom_range(0, lead_len(lead) - 1);
                repeat (m) str_q.insert(str_q.size(), 8'($urandom_range(8'h80, 8'hbf)));
                str_q.insert(str_q.size(),
                             $urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                                  : 8'($urandom_range(8'hc0, 8'hff)));
            end
            else
            begin
                str_q.insert(str_q.size(), 8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 4) == 0)
        begin
            // string cut short inside a sequence
            lead = 8'($urandom_range(8'hc0, 8'hf7));
            str_q.insert(str_q.size(), lead);
            m = $urandom_range(0, lead_len(lead) - 1);
            repeat (m) str_q.insert(str_q.size(), 8'($urandom_range(8'h80, 8'hbf)));
        end
        for (i = 0; i < str_q.size(); i++)
        begin
            r = '0;
            r.b = str_q[i];
            r.l = (i == str_q.size() - 1);
            send_req(r);
        end
        str_cnt++;
    endtask

    // receiver: random stall stretches, one long hold-off on request
    initial
    begin
        int len;
        int r;
        dst_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            r = $urandom_range(0, 99);
            if (long_hold)
            begin
                long_hold = 1'b0;
                dst_stall <= 1'b1;
                len = HOLD_CYCLES;
            end
            else if (r < 10)
            begin
                dst_stall <= 1'b0;
                len = $urandom_range(30, 80);
            end
            else if (r < 55)
            begin
                dst_stall <= 1'b0;
                len = $urandom_range(1, 8);
            end
            else if (r < 94)
            begin
                dst_stall <= 1'b1;
                len = $urandom_range(1, 3);
            end
            else
            begin
                dst_stall <= 1'b1;
                len = $urandom_range(10, 40);
            end
            repeat (len - 1) @(negedge clk);
        end
    end

    // result check
    always @(posedge clk)
    begin
        dst_t e;
        if (rst_n && dst_valid && !dst_stall)
        begin
            out_cnt++;
            if (norm_exp_q.size() == 0)
            begin
                if (bad_cnt < 10)
                begin
                    $display("unexpected output byte %02h run_end %0b stream_end %0b",
                             dst_data.out_byte, dst_data.out_run_end, dst_data.out_stream_end);
                end
                bad_cnt++;
            end
            else
            begin
                e = norm_exp_q.pop_front();
                if (dst_data.out_byte !== e.out_byte || dst_data.out_run_end !== e.out_run_end
                    || dst_data.out_stream_end !== e.out_stream_end)
                begin
                    if (bad_cnt < 10)
                    begin
                        $display("mismatch at output %0d: expected %02h/%0b/%0b got %02h/%0b/%0b",
                                 out_cnt, e.out_byte, e.out_run_end, e.out_stream_end,
                                 dst_data.out_byte, dst_data.out_run_end,
                                 dst_data.out_stream_end);
                    end
                    bad_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
            begin
                quiet_cnt <= 0;
            end
            else
            begin
                quiet_cnt <= quiet_cnt + 1;
            end
            if (quiet_cnt >= QUIET_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles, %0d outputs pending",
                         quiet_cnt, norm_exp_q.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        src_valid = 1'b0;
        src_data = '0;

        // extremes and stray bytes, outputs typed in
        add_row(8'h00, 1'b0, 2'd1, 8'h00, 8'h00, 8'h00);
        add_row(8'h7f, 1'b1, 2'd1, 8'h7f, 8'h00, 8'h00);
        add_row(8'h80, 1'b0, 2'd2, 8'hc2, 8'h80, 8'h00);
        add_row(8'hff, 1'b0, 2'd2, 8'hc3, 8'hbf, 8'h00);
        // lone lead byte at end of string, split letter
        add_row(8'hc0, 1'b1, 2'd3, 8'h41, 8'hcc, 8'h80);
        // two-byte accented letter, three-byte sequence, four-byte above u+10ffff
        add_row(8'hc3, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(8'ha9, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(8'he2, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(8'h82, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(8'hac, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(8'hf7, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(8'hbf, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(8'hbf, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(8'hbf, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        // broken sequence
        add_row(8'he2, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(8'h41, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
        // four-byte sequence cut short
        add_row(8'hf0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(8'h90, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(8'h80, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
        // full pending buffer broken by a lead byte that is itself cut short
        add_row(8'hf4, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(8'h80, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(8'h80, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(8'hc5, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            send_req(dir_rows[i]);
        end
        drain_pause();

        while (req_cnt < REQ_TARGET)
        begin
            if (str_cnt == 8)
            begin
                // receiver holds off while the sender keeps pushing
                long_hold = 1'b1;
                burst_left = 30;
            end
            else if (str_cnt == 15 || $urandom_range(0, 11) == 0)
            begin
                drain_pause();
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                burst_left = 30;
            end
            send_string();
        end

        src_valid <= 1'b0;
        while (norm_exp_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests in %0d strings, %0d output bytes checked, %0d letters split",
                 req_cnt, str_cnt, out_cnt, split_cnt);
        if (bad_cnt == 0 && norm_exp_q.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("%0d mismatches, %0d outputs missing", bad_cnt, norm_exp_q.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
